// ===== rtl/scl_pkg.sv =====
`default_nettype none

package scl_pkg;

  // Longest line handled; a non-newline byte at column LINE_LIMIT-2 or later is an error.
  localparam int unsigned LINE_LIMIT = 256;
  localparam logic [7:0] COL_LIMIT = 8'(LINE_LIMIT - 2);

  // Result buffer
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  // Lexer mode codes
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_WORD    = 3'd1;
  localparam logic [2:0] MODE_STRING  = 3'd2;
  localparam logic [2:0] MODE_COMMENT = 3'd3;
  localparam logic [2:0] MODE_ERROR   = 3'd4;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_EQUAL  = 8'h3d;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;

  typedef enum logic [4:0] {
    KIND_DEF        = 5'd0,
    KIND_FUNCTION   = 5'd1,
    KIND_RETURN     = 5'd2,
    KIND_ARROW      = 5'd3,
    KIND_LBRACE     = 5'd4,
    KIND_RBRACE     = 5'd5,
    KIND_LPAREN     = 5'd6,
    KIND_RPAREN     = 5'd7,
    KIND_COLON      = 5'd8,
    KIND_EQUAL      = 5'd9,
    KIND_SEMI       = 5'd10,
    KIND_NUMBER     = 5'd11,
    KIND_STRING     = 5'd12,
    KIND_IDENT      = 5'd13,
    KIND_EOL        = 5'd14,
    KIND_ERR_STRING = 5'd15,
    KIND_ERR_LONG   = 5'd16
  } kind_e;

  // Fixed words tracked while a word is collected: def, function, return, ->, //
  localparam int unsigned NUM_WORDS = 5;
  localparam int unsigned COMMENT_WORD = 4;
  localparam logic [7:0] KW_TEXT [NUM_WORDS][8] = '{
    '{"d", "e", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "u", "n", "c", "t", "i", "o", "n"},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
    '{"-", ">", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"/", "/", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [7:0] KW_LEN [NUM_WORDS] = '{8'd3, 8'd8, 8'd6, 8'd2, 8'd2};

  typedef struct packed {
    kind_e      kind;
    logic [7:0] start_column;
    logic [7:0] tok_len;
    logic       last;
  } result_t;

  // Results of one step, in delivery order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             room;
  } fifo_stat_t;

endpackage

`default_nettype wire

// ===== rtl/scl_core.sv =====
`default_nettype none

module scl_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire logic [7:0]     char_i,
  input  wire logic           eoi_i,
  output scl_pkg::push_t      push_o,
  output logic [2:0]          mode_o
);

  logic [2:0] mode_q, mode_d, mode_v;
  logic [7:0] col_q, col_d;
  logic [7:0] start_q, start_d;
  logic [7:0] len_q, len_d;
  logic [scl_pkg::NUM_WORDS-1:0] cand_q, cand_d;
  logic digit_q, digit_d;

  logic is_nl, is_quote, is_punct, is_delim, is_digit;
  logic [scl_pkg::NUM_WORDS-1:0] hit, add_cand, start_cand;
  logic fw_comment;
  scl_pkg::kind_e fw_kind, punct_kind;
  logic a_vld, b_vld;
  scl_pkg::result_t a_res, b_res;

  assign is_nl    = (char_i == scl_pkg::CH_NL);
  assign is_quote = (char_i == scl_pkg::CH_QUOTE);
  assign is_digit = (char_i >= scl_pkg::CH_ZERO) && (char_i <= scl_pkg::CH_NINE);
  assign is_punct = char_i inside {scl_pkg::CH_LBRACE, scl_pkg::CH_RBRACE, scl_pkg::CH_LPAREN,
                                   scl_pkg::CH_RPAREN, scl_pkg::CH_COLON, scl_pkg::CH_EQUAL,
                                   scl_pkg::CH_SEMI};
  assign is_delim = is_punct ||
                    char_i inside {scl_pkg::CH_SPACE, scl_pkg::CH_TAB, scl_pkg::CH_NUL,
                                   scl_pkg::CH_NL};

  always_comb begin
    case (char_i)
      scl_pkg::CH_LBRACE: punct_kind = scl_pkg::KIND_LBRACE;
      scl_pkg::CH_RBRACE: punct_kind = scl_pkg::KIND_RBRACE;
      scl_pkg::CH_LPAREN: punct_kind = scl_pkg::KIND_LPAREN;
      scl_pkg::CH_RPAREN: punct_kind = scl_pkg::KIND_RPAREN;
      scl_pkg::CH_COLON:  punct_kind = scl_pkg::KIND_COLON;
      scl_pkg::CH_EQUAL:  punct_kind = scl_pkg::KIND_EQUAL;
      default:            punct_kind = scl_pkg::KIND_SEMI;
    endcase
  end

  // Per-word candidate tracking and the match at word end
  always_comb begin
    for (int k = 0; k < scl_pkg::NUM_WORDS; k++) begin
      add_cand[k]   = cand_q[k] && (len_q < scl_pkg::KW_LEN[k]) &&
                      (scl_pkg::KW_TEXT[k][len_q[2:0]] == char_i);
      start_cand[k] = (scl_pkg::KW_TEXT[k][0] == char_i);
      hit[k]        = cand_q[k] && (len_q == scl_pkg::KW_LEN[k]);
    end
  end

  assign fw_comment = hit[scl_pkg::COMMENT_WORD];

  always_comb begin
    if (hit[0])      fw_kind = scl_pkg::KIND_DEF;
    else if (hit[1]) fw_kind = scl_pkg::KIND_FUNCTION;
    else if (hit[2]) fw_kind = scl_pkg::KIND_RETURN;
    else if (hit[3]) fw_kind = scl_pkg::KIND_ARROW;
    else if (digit_q) fw_kind = scl_pkg::KIND_NUMBER;
    else             fw_kind = scl_pkg::KIND_IDENT;
  end

  // One step: a is a finished word, b is the token caused by the byte itself
  always_comb begin
    mode_d  = mode_q;
    mode_v  = mode_q;
    col_d   = col_q;
    start_d = start_q;
    len_d   = len_q;
    cand_d  = cand_q;
    digit_d = digit_q;
    a_vld   = 1'b0;
    b_vld   = 1'b0;
    a_res.kind         = fw_kind;
    a_res.start_column = start_q;
    a_res.tok_len      = len_q;
    a_res.last         = 1'b0;
    b_res.kind         = scl_pkg::KIND_EOL;
    b_res.start_column = col_q;
    b_res.tok_len      = 8'd0;
    b_res.last         = 1'b1;

    if (mode_q != scl_pkg::MODE_ERROR) begin
      if (eoi_i) begin
        if (mode_q == scl_pkg::MODE_STRING) begin
          b_vld = 1'b1;
          b_res.kind = scl_pkg::KIND_ERR_STRING;
          b_res.start_column = start_q;
          b_res.tok_len = len_q;
          mode_d = scl_pkg::MODE_ERROR;
        end else begin
          a_vld = (mode_q == scl_pkg::MODE_WORD) && !fw_comment;
          b_vld = (col_q != 8'd0);
          col_d = 8'd0;
          mode_d = scl_pkg::MODE_IDLE;
        end
      end else if (!is_nl && (col_q >= scl_pkg::COL_LIMIT)) begin
        b_vld = 1'b1;
        b_res.kind = scl_pkg::KIND_ERR_LONG;
        mode_d = scl_pkg::MODE_ERROR;
      end else if (mode_q == scl_pkg::MODE_STRING) begin
        if (is_nl) begin
          b_vld = 1'b1;
          b_res.kind = scl_pkg::KIND_ERR_STRING;
          b_res.start_column = start_q;
          b_res.tok_len = len_q;
          mode_d = scl_pkg::MODE_ERROR;
        end else begin
          len_d = len_q + 8'd1;
          col_d = col_q + 8'd1;
          if (is_quote) begin
            b_vld = 1'b1;
            b_res.kind = scl_pkg::KIND_STRING;
            b_res.start_column = start_q;
            b_res.tok_len = len_q + 8'd1;
            mode_d = scl_pkg::MODE_IDLE;
          end
        end
      end else begin
        if ((mode_q == scl_pkg::MODE_WORD) && is_delim) begin
          if (fw_comment) begin
            mode_v = scl_pkg::MODE_COMMENT;
          end else begin
            a_vld  = 1'b1;
            mode_v = scl_pkg::MODE_IDLE;
          end
        end
        mode_d = mode_v;
        case (mode_v)
          scl_pkg::MODE_WORD: begin
            len_d  = len_q + 8'd1;
            cand_d = add_cand;
            col_d  = col_q + 8'd1;
          end
          scl_pkg::MODE_COMMENT: begin
            if (is_nl) begin
              b_vld  = 1'b1;
              col_d  = 8'd0;
              mode_d = scl_pkg::MODE_IDLE;
            end else begin
              col_d = col_q + 8'd1;
            end
          end
          default: begin
            if (is_nl) begin
              b_vld = 1'b1;
              col_d = 8'd0;
            end else begin
              if (is_punct) begin
                b_vld = 1'b1;
                b_res.kind = punct_kind;
                b_res.tok_len = 8'd1;
              end else if (is_quote) begin
                mode_d  = scl_pkg::MODE_STRING;
                start_d = col_q;
                len_d   = 8'd1;
              end else if (!is_delim) begin
                mode_d  = scl_pkg::MODE_WORD;
                start_d = col_q;
                len_d   = 8'd1;
                cand_d  = start_cand;
                digit_d = is_digit;
              end
              col_d = col_q + 8'd1;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    push_o.count  = step_i ? ({1'b0, a_vld} + {1'b0, b_vld}) : 2'd0;
    push_o.first  = a_vld ? a_res : b_res;
    push_o.first.last = !(a_vld && b_vld);
    push_o.second = b_res;
  end

  assign mode_o = mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= scl_pkg::MODE_IDLE;
      col_q   <= 8'd0;
      start_q <= 8'd0;
      len_q   <= 8'd0;
      cand_q  <= '0;
      digit_q <= 1'b0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      col_q   <= col_d;
      start_q <= start_d;
      len_q   <= len_d;
      cand_q  <= cand_d;
      digit_q <= digit_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/scl_fifo.sv =====
`default_nettype none

module scl_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  scl_pkg::push_t        push_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output scl_pkg::result_t      data_o,
  output scl_pkg::fifo_stat_t   stat_o
);

  scl_pkg::result_t mem [scl_pkg::FIFO_DEPTH];
  logic [scl_pkg::PTR_W-1:0] wr_q, rd_q;
  logic [scl_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem[rd_q];
  assign cnt_d   = cnt_q + scl_pkg::CNT_W'(push_i.count) - scl_pkg::CNT_W'(pop);

  assign stat_o.count = cnt_q;
  assign stat_o.room  = (cnt_q <= scl_pkg::CNT_W'(scl_pkg::FIFO_DEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem[wr_q + scl_pkg::PTR_W'(1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + scl_pkg::PTR_W'(push_i.count);
      rd_q  <= rd_q + scl_pkg::PTR_W'(pop);
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/source_character_lexer_unit.sv =====
// Streaming lexer: one source byte per beat in, tokens (kind, start column, length) out.
// Each accepted byte lands in an input register and is lexed once the buffer has room; its
// zero, one or two tokens are written into a four-entry result buffer that drives the
// output stream, so a token is offered only after its byte has been lexed and buffered.
// A byte is lexed whenever the buffer has two free entries, so the unit takes one byte
// per cycle as long as the output side drains a token per cycle; bytes that yield two
// tokens (a word ended by punctuation or a newline, or end of input) can fill the buffer
// and hold the input while the output side stalls. tuser marks end of input:
// it flushes the pending word and ends the last line, and tdata is ignored on that beat.
// tlast flags the final token caused by one input beat. After an unterminated string or
// an over-long line the error token is sent and all further input is swallowed until
// reset.
`default_nettype none

module source_character_lexer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  wire logic        s_axis_tuser,   // [0] end_of_input
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [4:0] token_kind, [12:5] start_column,
                                           // [20:13] tok_len, [23:21] zero
  output logic             m_axis_tlast    // last token of its input beat
);

  // Input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_char_q;
  logic       in_eoi_q;
  logic       step;
  logic       in_take;

  scl_pkg::push_t      push;
  scl_pkg::fifo_stat_t fstat;
  scl_pkg::result_t    res;
  logic [2:0]          mode;

  // Lex the held byte only when both of its possible tokens fit
  assign step          = in_vld_q && fstat.room;
  assign s_axis_tready = !in_vld_q || step;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end else begin
      in_vld_d = in_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // Payload: load on every accepted beat
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q <= s_axis_tdata;
      in_eoi_q  <= s_axis_tuser;
    end
  end

  scl_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .char_i (in_char_q),
    .eoi_i  (in_eoi_q),
    .push_o (push),
    .mode_o (mode)
  );

  scl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (res),
    .stat_o  (fstat)
  );

  assign m_axis_tdata = {3'b000, res.tok_len, res.start_column, res.kind};
  assign m_axis_tlast = res.last;

  // The result buffer never holds more than its depth
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstat.count <= scl_pkg::CNT_W'(scl_pkg::FIFO_DEPTH))
    else $error("result buffer overfilled");

  // Tokens are only pushed when a held byte is lexed
  a_push_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.count != 2'd0) |-> step)
    else $error("tokens pushed without a lexing step");

  // The error state latches until reset
  a_error_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode == scl_pkg::MODE_ERROR) |=> (mode == scl_pkg::MODE_ERROR))
    else $error("lexer left the error state");

  // Nothing is produced once the error state is reached
  a_error_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode == scl_pkg::MODE_ERROR) |-> (push.count == 2'd0))
    else $error("token produced after an error");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned NUM_KW       = 5;
  localparam int unsigned SLASH_WORD   = 4;     // "//" opens a comment, never a token
  localparam int unsigned RANDOM_ITEMS = 1950;
  localparam int unsigned DRAIN_AT     = 700;   // sender waits for an empty ledger here
  localparam int unsigned MAX_REPORTS  = 10;

  typedef enum {LX_IDLE, LX_WORD, LX_STRING, LX_COMMENT, LX_ERROR} lex_mode_e;

  typedef struct {
    scl_pkg::kind_e kind;
    logic [7:0]     col;
    logic [7:0]     len;
    logic           last;
  } token_t;

  // Tracks the lexer state and holds the tokens still due on the output stream.
  class token_ledger;
    token_t      tokens_due[$];
    token_t      step_tokens[$];
    int unsigned mismatches;
    lex_mode_e   mode;
    int unsigned column;
    int unsigned word_start;
    int unsigned word_len;
    logic [NUM_KW-1:0] candidates;
    bit          digit_first;
    string       kw_text[NUM_KW];
    int unsigned kw_len[NUM_KW];
    scl_pkg::kind_e kw_kind[NUM_KW-1];

    function new();
      kw_text = '{"def", "function", "return", "->", "//"};
      foreach (kw_text[k]) kw_len[k] = kw_text[k].len();
      kw_kind = '{scl_pkg::KIND_DEF, scl_pkg::KIND_FUNCTION, scl_pkg::KIND_RETURN,
                  scl_pkg::KIND_ARROW};
      mode = LX_IDLE;
      column = 0;
      word_start = 0;
      word_len = 0;
      candidates = '0;
      digit_first = 1'b0;
      mismatches = 0;
    endfunction

    function void emit(input scl_pkg::kind_e kind, input int unsigned col,
                       input int unsigned len);
      step_tokens.push_back('{kind, 8'(col), 8'(len), 1'b0});
    endfunction

    function bit punct_kind(input logic [7:0] ch, output scl_pkg::kind_e kind);
      punct_kind = 1'b1;
      kind = scl_pkg::KIND_LBRACE;
      case (ch)
        "{": kind = scl_pkg::KIND_LBRACE;
        "}": kind = scl_pkg::KIND_RBRACE;
        "(": kind = scl_pkg::KIND_LPAREN;
        ")": kind = scl_pkg::KIND_RPAREN;
        ":": kind = scl_pkg::KIND_COLON;
        "=": kind = scl_pkg::KIND_EQUAL;
        ";": kind = scl_pkg::KIND_SEMI;
        default: punct_kind = 1'b0;
      endcase
    endfunction

    function bit separates(input logic [7:0] ch);
      scl_pkg::kind_e k;
      return ch == " " || ch == "\t" || ch == 8'h00 || ch == "\n" || punct_kind(ch, k);
    endfunction

    // Drop every fixed word that no longer matches, then count the character.
    function void take_char(input logic [7:0] ch);
      for (int k = 0; k < NUM_KW; k++) begin
        if (word_len >= kw_len[k] || kw_text[k][word_len] != ch) candidates[k] = 1'b0;
      end
      word_len++;
    endfunction

    function void close_word();
      bit found;
      found = 1'b0;
      for (int k = 0; k < NUM_KW; k++) begin
        if (!found && candidates[k] && word_len == kw_len[k]) begin
          found = 1'b1;
          if (k == SLASH_WORD) begin
            mode = LX_COMMENT;
          end else begin
            mode = LX_IDLE;
            emit(kw_kind[k], word_start, word_len);
          end
        end
      end
      if (!found) begin
        mode = LX_IDLE;
        emit(digit_first ? scl_pkg::KIND_NUMBER : scl_pkg::KIND_IDENT, word_start, word_len);
      end
    endfunction

    function void note_char(input logic [7:0] ch, input logic eoi);
      scl_pkg::kind_e pk;
      step_tokens.delete();
      if (mode == LX_ERROR) begin
        // swallow everything once an error has latched
      end else if (eoi) begin
        if (mode == LX_STRING) begin
          emit(scl_pkg::KIND_ERR_STRING, word_start, word_len);
          mode = LX_ERROR;
        end else begin
          if (mode == LX_WORD) close_word();
          if (column != 0) emit(scl_pkg::KIND_EOL, column, 0);
          column = 0;
          mode = LX_IDLE;
        end
      end else if (ch != "\n" && column >= scl_pkg::LINE_LIMIT - 2) begin
        emit(scl_pkg::KIND_ERR_LONG, column, 0);
        mode = LX_ERROR;
      end else if (mode == LX_STRING) begin
        if (ch == "\n") begin
          emit(scl_pkg::KIND_ERR_STRING, word_start, word_len);
          mode = LX_ERROR;
        end else begin
          word_len++;
          column++;
          if (ch == "\"") begin
            emit(scl_pkg::KIND_STRING, word_start, word_len);
            mode = LX_IDLE;
          end
        end
      end else begin
        if (mode == LX_WORD && separates(ch)) close_word();
        if (mode == LX_WORD) begin
          take_char(ch);
          column++;
        end else if (mode == LX_COMMENT) begin
          if (ch == "\n") begin
            emit(scl_pkg::KIND_EOL, column, 0);
            column = 0;
            mode = LX_IDLE;
          end else begin
            column++;
          end
        end else if (ch == "\n") begin
          emit(scl_pkg::KIND_EOL, column, 0);
          column = 0;
        end else begin
          if (punct_kind(ch, pk)) begin
            emit(pk, column, 1);
          end else if (ch == "\"") begin
            mode = LX_STRING;
            word_start = column;
            word_len = 1;
          end else if (!separates(ch)) begin
            mode = LX_WORD;
            word_start = column;
            word_len = 0;
            candidates = '1;
            digit_first = (ch >= "0" && ch <= "9");
            take_char(ch);
          end
          column++;
        end
      end
      if (step_tokens.size() != 0) step_tokens[step_tokens.size()-1].last = 1'b1;
      foreach (step_tokens[j]) tokens_due.push_back(step_tokens[j]);
    endfunction

    function void check_token(input logic [23:0] data, input logic last);
      token_t want;
      if (tokens_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected token: kind %0d col %0d len %0d last %0b",
                   data[4:0], data[12:5], data[20:13], last);
      end else begin
        want = tokens_due.pop_front();
        if (data[4:0] !== want.kind || data[12:5] !== want.col || data[20:13] !== want.len ||
            data[23:21] !== 3'b000 || last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $write("token mismatch: expected kind %0d col %0d len %0d last %0b, ",
                   want.kind, want.col, want.len, want.last);
            $display("got kind %0d col %0d len %0d pad %0d last %0b",
                     data[4:0], data[12:5], data[20:13], data[23:21], last);
          end
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] char_code
  logic        s_axis_tuser = 1'b0;    // [0] end_of_input
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;           // [4:0] kind, [12:5] start column, [20:13] length
  logic        m_axis_tlast;

  token_ledger ledger = new();

  source_character_lexer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // Check the outgoing beat first: no byte can yield a token in the cycle it is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) ledger.check_token(m_axis_tdata, m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready) ledger.note_char(s_axis_tdata, s_axis_tuser);
    end
  end

  // Offer one beat from a falling edge and hold it until taken.
  task automatic send_item(input logic [7:0] ch, input logic eoi);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= eoi;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // Receiver: random stall segments, plus a long periodic hold-off.
  int unsigned rx_cycle = 0;
  int unsigned hold_left = 0;
  int unsigned seg_left = 0;
  int unsigned stall_pct = 0;

  initial begin
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_cycle % 3000 == 1000) begin
        hold_left = 300;
        m_axis_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(1, 60);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        seg_left--;
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    #1000000;
    $display("source_character_lexer_unit test failed");
    $finish;
  end

  string       key_words[4] = '{"def", "function", "return", "->"};
  string       near_words[13] = '{"de", "deff", "func", "functions", "retur", "returned", "-",
                                  ">", "->-", "///", "//x", "def\"", "d"};
  logic [8:0]  frag_q[$];
  logic [7:0]  ch;
  logic [7:0]  rnd;
  logic        eoi;
  int unsigned sent = 0;
  int unsigned burst_left = 0;
  int unsigned gap = 0;
  int unsigned n = 0;
  int unsigned tail = 0;
  string       word;

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: keyword ended by punctuation, string then glued word, NUL separator,
    // arrow ended by newline, comment eating punctuation, empty-line end of input,
    // quote inside a word with top-bit byte, end of input flushing a word.
    send_text("def(\"q\"z");
    send_item(8'h00, 1'b0);
    send_text(";->\n//\t{\n");
    send_item(8'h00, 1'b1);
    send_text("a\"b");
    send_item(8'hff, 1'b0);
    send_item(8'h5a, 1'b1);

    // Random: fragments of source text glued together, with noise mixed in.
    while (sent < RANDOM_ITEMS) begin
      if (frag_q.size() == 0) begin
        case ($urandom_range(0, 19))
          0, 1, 18: begin
            word = key_words[$urandom_range(0, 3)];
            for (int i = 0; i < word.len(); i++) frag_q.push_back({1'b0, word[i]});
          end
          2: begin
            word = near_words[$urandom_range(0, 12)];
            for (int i = 0; i < word.len(); i++) frag_q.push_back({1'b0, word[i]});
          end
          3, 4, 19: begin
            frag_q.push_back({1'b0, ($urandom_range(0, 5) == 0) ? 8'h5f :
                                    8'(8'h61 + $urandom_range(0, 25))});
            n = $urandom_range(0, 7);
            repeat (n) begin
              case ($urandom_range(0, 9))
                0: rnd = "\"";
                1, 2: rnd = 8'(8'h30 + $urandom_range(0, 9));
                3: rnd = 8'(8'h41 + $urandom_range(0, 25));
                default: rnd = 8'(8'h61 + $urandom_range(0, 25));
              endcase
              frag_q.push_back({1'b0, rnd});
            end
          end
          5: begin
            frag_q.push_back({1'b0, 8'(8'h30 + $urandom_range(0, 9))});
            n = $urandom_range(0, 5);
            repeat (n) frag_q.push_back({1'b0, ($urandom_range(0, 3) == 0) ?
                                         8'(8'h61 + $urandom_range(0, 25)) :
                                         8'(8'h30 + $urandom_range(0, 9))});
          end
          6: begin
            frag_q.push_back({1'b0, 8'h22});
            n = $urandom_range(0, 8);
            repeat (n) begin
              do rnd = 8'($urandom_range(0, 255)); while (rnd == "\"" || rnd == "\n");
              frag_q.push_back({1'b0, rnd});
            end
            frag_q.push_back({1'b0, 8'h22});
          end
          7, 8: begin
            word = "(){}:=;";
            frag_q.push_back({1'b0, word[$urandom_range(0, 6)]});
          end
          9, 10: begin
            n = $urandom_range(1, 3);
            repeat (n) begin
              case ($urandom_range(0, 2))
                0: frag_q.push_back({1'b0, 8'h20});
                1: frag_q.push_back({1'b0, 8'h09});
                default: frag_q.push_back({1'b0, 8'h00});
              endcase
            end
          end
          11: frag_q.push_back({1'b0, 8'h0a});
          12: begin
            frag_q.push_back({1'b0, 8'h2f});
            frag_q.push_back({1'b0, 8'h2f});
            word = " \t(";
            frag_q.push_back({1'b0, word[$urandom_range(0, 2)]});
            n = $urandom_range(0, 10);
            repeat (n) begin
              do rnd = 8'($urandom_range(0, 255)); while (rnd == "\n");
              frag_q.push_back({1'b0, rnd});
            end
            frag_q.push_back({1'b0, 8'h0a});
          end
          13: begin
            n = $urandom_range(1, 4);
            repeat (n) frag_q.push_back({1'b0, 8'($urandom_range(0, 255))});
          end
          14: frag_q.push_back({1'b1, 8'($urandom_range(0, 255))});
          15, 16: begin
            // word glued straight onto punctuation and a string
            frag_q.push_back({1'b0, 8'(8'h61 + $urandom_range(0, 25))});
            word = "(){}:=;";
            frag_q.push_back({1'b0, word[$urandom_range(0, 6)]});
            frag_q.push_back({1'b0, 8'h22});
            frag_q.push_back({1'b0, 8'(8'h61 + $urandom_range(0, 25))});
            frag_q.push_back({1'b0, 8'h22});
          end
          default: begin
            // rare long word to push columns and lengths to the line limit
            if ($urandom_range(0, 40) == 0) begin
              n = $urandom_range(100, 253);
              repeat (n) frag_q.push_back({1'b0, 8'(8'h61 + $urandom_range(0, 25))});
            end else begin
              frag_q.push_back({1'b0, 8'h20});
            end
          end
        endcase
      end else begin
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) :
                                                     $urandom_range(1, 40);
          gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
        end else begin
          gap = 0;
        end
        if (sent == DRAIN_AT) begin
          s_axis_tvalid <= 1'b0;
          do @(negedge clk_i); while (ledger.tokens_due.size() != 0);
        end else if (gap != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        burst_left--;
        {eoi, ch} = frag_q.pop_front();
        // Keep clear of errors here: close an open string before a line ends or the
        // limit nears, open no string that close to the limit, and break a line before
        // it grows too long.
        if (ledger.mode == LX_STRING && (eoi || ch == "\n" || ledger.column >= 252)) begin
          ch = "\"";
          eoi = 1'b0;
        end else if (!eoi && ch != "\n" && (ledger.column >= scl_pkg::LINE_LIMIT - 2 ||
                                            (ch == "\"" && ledger.column >= 252))) begin
          ch = "\n";
        end
        send_item(ch, eoi);
        sent++;
      end
    end

    // Finish with one latched error, then feed bytes that must be swallowed.
    if (ledger.mode == LX_STRING) send_item("\"", 1'b0);
    send_item("\n", 1'b0);
    tail = $urandom_range(0, 2);
    if (tail == 2) begin
      while (ledger.mode != LX_ERROR) send_item("x", 1'b0);
    end else begin
      send_text("\"ab");
      send_item((tail == 1) ? 8'($urandom_range(0, 255)) : 8'h0a, tail == 1);
    end
    n = $urandom_range(4, 12);
    repeat (n) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    s_axis_tvalid <= 1'b0;

    while (ledger.tokens_due.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    if (ledger.mismatches == 0 && ledger.tokens_due.size() == 0) begin
      $display("source_character_lexer_unit test passed");
    end else begin
      $display("source_character_lexer_unit test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/scl_pkg.sv
rtl/scl_core.sv
rtl/scl_fifo.sv
rtl/source_character_lexer_unit.sv
verif/tb_top.sv
